// ===== rtl/core/ratune_pkg.sv =====
package ratune_pkg;

    localparam int TempW   = 13;
    localparam int StoreW  = 16;
    localparam int TickW   = 16;
    localparam int DutyW   = 8;
    localparam int CoefW   = 16;
    localparam int GainW   = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;
    localparam int NumW    = 48;
    localparam int DenW    = 32;

    localparam logic [4:0] SampleMask  = 5'h1F;
    localparam int         SettleLimit = 30;
    localparam int         PeakLimit   = 19;

    localparam int DefPShift = 0;
    localparam int DefIShift = 0;
    localparam int DefDShift = 0;

    localparam logic [CfgIdxW-1:0] CFG_START_DUTY = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_SWING_DUTY = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_COEF_P     = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_COEF_I     = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_COEF_D     = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_GO     = 3'd1,
        PH_SETTLE = 3'd2,
        PH_INIT   = 3'd3,
        PH_MIN    = 3'd4,
        PH_MAX    = 3'd5,
        PH_DONE   = 3'd6,
        PH_FAIL   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_STEP,
        C_MUL,
        C_DIV,
        C_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       step;      // apply one tick's phase update
        logic       mul;       // form numerators and denominators
        logic       div_start; // launch the shared divider
        logic [1:0] div_sel;   // which gain the divider works on
        logic       out_load;  // capture the result into the output stage
    } dp_cmd_t;

    typedef struct packed {
        logic       need_gains; // the last step finished the tuning
        logic       div_busy;
    } dp_stat_t;

endpackage

// ===== rtl/core/ratune_divider.sv =====
module ratune_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ratune_pkg::NumW-1:0]   num,
    input  logic [ratune_pkg::DenW-1:0]   den,
    output logic                          busy,
    output logic [ratune_pkg::NumW-1:0]   quot
);
    import ratune_pkg::*;

    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] quot_reg, quot_next;
    logic [DenW:0]   rem_reg, rem_next;
    logic [DenW-1:0] den_reg, den_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DenW:0]   trial;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DenW-1:0], quot_reg[NumW-1]};
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NumW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/ratune_datapath.sv =====
module ratune_datapath #(
    parameter int P_SHIFT = ratune_pkg::DefPShift,
    parameter int I_SHIFT = ratune_pkg::DefIShift,
    parameter int D_SHIFT = ratune_pkg::DefDShift
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ratune_pkg::dp_cmd_t              cmd,
    output ratune_pkg::dp_stat_t             stat,
    input  logic                             cfg_we,
    input  logic [ratune_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ratune_pkg::CfgW-1:0]      cfg_data,
    input  logic signed [ratune_pkg::TempW-1:0] temp_in,
    input  logic                             req_in,
    output logic [ratune_pkg::DutyW-1:0]     duty_o,
    output logic [2:0]                       phase_o,
    output logic                             point_o,
    output logic [ratune_pkg::GainW-1:0]     gp_o,
    output logic [ratune_pkg::GainW-1:0]     gi_o,
    output logic [ratune_pkg::GainW-1:0]     gd_o,
    output logic                             gv_o
);
    import ratune_pkg::*;

    // Configuration registers.
    logic [7:0]       start_duty_reg, swing_duty_reg, hyst_reg;
    logic [CoefW-1:0] coef_p_reg, coef_i_reg, coef_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_duty_reg <= 8'd72;
            swing_duty_reg <= 8'd64;
            hyst_reg       <= 8'd2;
            coef_p_reg     <= 16'd3441;
            coef_i_reg     <= 16'd6883;
            coef_d_reg     <= 16'd1146;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_DUTY: start_duty_reg <= cfg_data[7:0];
                CFG_SWING_DUTY: swing_duty_reg <= cfg_data[7:0];
                CFG_HYSTERESIS: hyst_reg       <= cfg_data[7:0];
                CFG_COEF_P:     coef_p_reg     <= cfg_data;
                CFG_COEF_I:     coef_i_reg     <= cfg_data;
                CFG_COEF_D:     coef_d_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tuning state.
    phase_t                   phase_reg, phase_next;
    logic [TickW-1:0]         tick_reg, tick_next;
    logic signed [StoreW-1:0] pk_reg [4];
    logic signed [StoreW-1:0] pk_next [4];
    logic [TickW-1:0]         pt_reg [2];
    logic [TickW-1:0]         pt_next [2];
    logic signed [StoreW-1:0] base_reg, base_next;
    logic [7:0]               pidx_reg, pidx_next;
    logic [DutyW-1:0]         duty_reg, duty_next;
    logic                     point_reg, point_next;
    logic                     need_reg, need_next;

    logic signed [17:0] t, h, base_x, lo_b, hi_b;
    logic [DutyW-1:0]   lowd, highd;
    logic signed [17:0] mn, mx, sum4, d0, d1;
    logic [1:0]         slot, slotn;
    logic [TickW-1:0]   nidx;
    logic signed [StoreW-1:0] s [4];
    logic [7:0]         pinc;

    always_comb
    begin
        t      = 18'(temp_in);
        h      = 18'(hyst_reg);
        base_x = 18'(base_reg);
        lo_b   = base_x - h;
        hi_b   = base_x + h;
        lowd   = start_duty_reg - swing_duty_reg;
        highd  = start_duty_reg + swing_duty_reg;

        phase_next = phase_reg;
        tick_next  = tick_reg + 1'b1;
        for (int k = 0; k < 4; k++) pk_next[k] = pk_reg[k];
        for (int k = 0; k < 2; k++) pt_next[k] = pt_reg[k];
        base_next  = base_reg;
        pidx_next  = pidx_reg;
        duty_next  = duty_reg;
        point_next = point_reg;
        need_next  = 1'b0;

        nidx  = tick_next >> 5;
        slot  = pidx_reg[1:0];
        pinc  = pidx_reg + 1'b1;
        slotn = pinc[1:0];
        for (int k = 0; k < 4; k++) s[k] = pk_reg[k];
        s[nidx[1:0]] = StoreW'(t);
        mn = 18'(s[0]);
        mx = 18'(s[0]);
        for (int k = 1; k < 4; k++)
        begin
            if (18'(s[k]) < mn) mn = 18'(s[k]);
            if (18'(s[k]) > mx) mx = 18'(s[k]);
        end
        sum4 = 18'(s[0]) + 18'(s[1]) + 18'(s[2]) + 18'(s[3]);
        d0 = 18'(pk_reg[2]) - 18'(pk_reg[0]);
        d1 = 18'(pk_reg[3]) - 18'(pk_reg[1]);
        if (d0 < 0) d0 = -d0;
        if (d1 < 0) d1 = -d1;

        if (req_in && (phase_reg == PH_IDLE || phase_reg == PH_DONE || phase_reg == PH_FAIL))
            phase_next = PH_GO;
        else
        begin
            unique case (phase_reg)
                PH_IDLE: duty_next = '0;
                PH_GO:
                begin
                    duty_next  = start_duty_reg;
                    tick_next  = '0;
                    phase_next = PH_SETTLE;
                end
                PH_SETTLE:
                begin
                    point_next = tick_next[0];
                    duty_next  = start_duty_reg;
                    if ((tick_next[4:0] & SampleMask) == 5'd0)
                    begin
                        pk_next[nidx[1:0]] = StoreW'(t);
                        if (nidx >= 16'd3 && (mx - mn) <= h)
                        begin
                            duty_next  = lowd;
                            base_next  = StoreW'(sum4 >>> 2);
                            point_next = 1'b1;
                            phase_next = PH_INIT;
                        end
                        else if (nidx >= TickW'(SettleLimit))
                            phase_next = PH_FAIL;
                    end
                end
                PH_INIT:
                begin
                    if (t < lo_b)
                    begin
                        duty_next  = highd;
                        pidx_next  = '0;
                        pk_next[0] = StoreW'(t);
                        point_next = 1'b0;
                        tick_next  = '0;
                        phase_next = PH_MIN;
                    end
                end
                PH_MIN:
                begin
                    if (t < 18'(pk_reg[slot])) pk_next[slot] = StoreW'(t);
                    if (t > hi_b)
                    begin
                        pidx_next      = pinc;
                        pk_next[slotn] = StoreW'(t);
                        pt_next[pinc[1]] = tick_next;
                        duty_next  = lowd;
                        point_next = 1'b1;
                        phase_next = PH_MAX;
                    end
                end
                PH_MAX:
                begin
                    if (t > 18'(pk_reg[slot]))
                    begin
                        pk_next[slot]        = StoreW'(t);
                        pt_next[pidx_reg[1]] = tick_next;
                    end
                    if (t < lo_b)
                    begin
                        // Agreement is judged on the stores before this tick's update,
                        // which cannot change them: t is below every max here.
                        if (pidx_reg >= 8'd3 && d0 <= h && d1 <= h)
                        begin
                            need_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (pidx_reg >= 8'(PeakLimit))
                            phase_next = PH_FAIL;
                        else
                        begin
                            pidx_next      = pinc;
                            pk_next[slotn] = StoreW'(t);
                            duty_next  = highd;
                            point_next = 1'b0;
                            phase_next = PH_MIN;
                        end
                    end
                end
                PH_DONE:
                begin
                    point_next = 1'b1;
                    duty_next  = '0;
                end
                default:
                begin
                    point_next = 1'b1;
                    duty_next  = '0;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            for (int k = 0; k < 4; k++) pk_reg[k] <= '0;
            for (int k = 0; k < 2; k++) pt_reg[k] <= '0;
            base_reg  <= '0;
            pidx_reg  <= '0;
            duty_reg  <= '0;
            point_reg <= 1'b0;
            need_reg  <= 1'b0;
        end
        else if (cmd.step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            for (int k = 0; k < 4; k++) pk_reg[k] <= pk_next[k];
            for (int k = 0; k < 2; k++) pt_reg[k] <= pt_next[k];
            base_reg  <= base_next;
            pidx_reg  <= pidx_next;
            duty_reg  <= duty_next;
            point_reg <= point_next;
            need_reg  <= need_next;
        end
    end

    // Gain operands, formed over two registered multiply stages.
    logic [StoreW:0]  amp;
    logic [TickW-1:0] per;
    logic signed [17:0] ad, pd;
    logic [23:0]      cp_sw, ci_sw, cd_sw;
    logic [StoreW:0]  amp_reg;
    logic [TickW-1:0] per_reg;
    logic [DenW-1:0]  den_i_reg;
    logic [NumW-1:0]  num_d_reg;

    always_comb
    begin
        ad = 18'(pk_reg[pidx_reg[1:0]]) - 18'(pk_reg[2'(pidx_reg - 1'b1)]);
        if (ad < 0) ad = -ad;
        amp = ad[StoreW:0];
        pd = 18'(signed'({1'b0, pt_reg[1]})) - 18'(signed'({1'b0, pt_reg[0]}));
        if (pd < 0) pd = -pd;
        per = pd[TickW-1:0];
        cp_sw = coef_p_reg * swing_duty_reg;
        ci_sw = coef_i_reg * swing_duty_reg;
        cd_sw = coef_d_reg * swing_duty_reg;
    end

    logic [23:0] cp_reg, ci_reg, cd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            amp_reg <= amp;
            per_reg <= per;
            cp_reg  <= cp_sw;
            ci_reg  <= ci_sw;
            cd_reg  <= cd_sw;
        end
        // Second products use the first stage's registers.
        den_i_reg <= DenW'(amp_reg * per_reg);
        num_d_reg <= NumW'(cd_reg * per_reg);
    end

    logic [NumW-1:0] div_num;
    logic [DenW-1:0] div_den;
    logic [NumW-1:0] quot;
    logic            dbusy;

    always_comb
    begin
        case (cmd.div_sel)
            2'd0:    begin div_num = NumW'(cp_reg); div_den = DenW'(amp_reg); end
            2'd1:    begin div_num = NumW'(ci_reg); div_den = den_i_reg;      end
            default: begin div_num = num_d_reg;     div_den = DenW'(amp_reg); end
        endcase
    end

    ratune_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (dbusy),
        .quot  (quot)
    );

    logic [GainW-1:0] g_reg [3];
    logic [GainW-1:0] gq;
    logic             zero_den;
    logic [1:0]       cap_sel_reg;
    logic             cap_pend_reg;

    always_comb
    begin
        zero_den = (div_den == '0);
        case (cap_sel_reg)
            2'd0:    gq = GainW'(quot >> P_SHIFT);
            2'd1:    gq = GainW'(quot >> I_SHIFT);
            default: gq = GainW'(quot >> D_SHIFT);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_pend_reg <= 1'b0;
            cap_sel_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            cap_pend_reg <= 1'b1;
            cap_sel_reg  <= cmd.div_sel;
        end
        else if (cap_pend_reg && !dbusy)
            cap_pend_reg <= 1'b0;
    end

    logic zero_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
            zero_reg <= zero_den;
        if (cap_pend_reg && !dbusy && !cmd.div_start)
            g_reg[cap_sel_reg] <= zero_reg ? {GainW{1'b1}} : gq;
    end

    // Result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_o  <= '0;
            phase_o <= PH_IDLE;
            point_o <= 1'b0;
            gp_o    <= '0;
            gi_o    <= '0;
            gd_o    <= '0;
            gv_o    <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            duty_o  <= duty_reg;
            phase_o <= phase_reg;
            point_o <= point_reg;
            gp_o    <= need_reg ? g_reg[0] : '0;
            gi_o    <= need_reg ? g_reg[1] : '0;
            gd_o    <= need_reg ? g_reg[2] : '0;
            gv_o    <= need_reg;
        end
    end

    assign stat.need_gains = need_reg;
    assign stat.div_busy   = dbusy | cap_pend_reg;

endmodule

// ===== rtl/core/ratune_ctrl.sv =====
module ratune_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 out_stall,
    output logic                 out_valid,
    input  ratune_pkg::dp_stat_t stat,
    output ratune_pkg::dp_cmd_t  cmd
);
    import ratune_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [1:0]  sel_reg, sel_next;
    logic [1:0]  wait_reg, wait_next;
    logic        ov_reg, ov_next;
    logic        started_reg, started_next;

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        wait_next    = wait_reg;
        ov_next      = ov_reg && out_stall;
        started_next = started_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        unique case (state_reg)
            C_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = C_STEP;
                end
            end
            C_STEP:
            begin
                if (stat.need_gains)
                begin
                    cmd.mul    = 1'b1;
                    wait_next  = 2'd2;
                    state_next = C_MUL;
                end
                else
                    state_next = C_OUT;
            end
            C_MUL:
            begin
                // Let the second multiply stage settle.
                wait_next = wait_reg - 1'b1;
                if (wait_reg == 2'd0)
                begin
                    sel_next     = 2'd0;
                    started_next = 1'b0;
                    state_next   = C_DIV;
                end
            end
            C_DIV:
            begin
                cmd.div_sel = sel_reg;
                if (!started_reg)
                begin
                    cmd.div_start = 1'b1;
                    started_next  = 1'b1;
                end
                else if (!stat.div_busy)
                begin
                    started_next = 1'b0;
                    if (sel_reg == 2'd2)
                        state_next = C_OUT;
                    else
                        sel_next = sel_reg + 1'b1;
                end
            end
            C_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= C_IDLE;
            sel_reg     <= '0;
            wait_reg    <= '0;
            ov_reg      <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            wait_reg    <= wait_next;
            ov_reg      <= ov_next;
            started_reg <= started_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== rtl/core/relay_autotune_pid_gains_top.sv =====
// Relay-oscillation PID autotuner. Each request is one tick of the control loop and yields
// exactly one result. On an ordinary tick the controller goes from its step state to its
// output state and loads the result there unless the previous result is still stalled. The
// tick that completes tuning runs the three gain divisions one after another through one
// shared 48-bit radix-2 divider before its result is loaded. Input is accepted again once
// the result is loaded into the output register, so the next tick may arrive while that
// result still waits.
module relay_autotune_pid_gains_top #(
    parameter int P_SHIFT = ratune_pkg::DefPShift,
    parameter int I_SHIFT = ratune_pkg::DefIShift,
    parameter int D_SHIFT = ratune_pkg::DefDShift
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ratune_pkg::CfgIdxW-1:0]        cfg_index,
    input  logic [ratune_pkg::CfgW-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ratune_pkg::TempW-1:0]   temp_sample,
    input  logic                                  start_req,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ratune_pkg::DutyW-1:0]          duty,
    output logic [2:0]                            phase,
    output logic                                  point_led,
    output logic [ratune_pkg::GainW-1:0]          gain_p,
    output logic [ratune_pkg::GainW-1:0]          gain_i,
    output logic [ratune_pkg::GainW-1:0]          gain_d,
    output logic                                  gains_valid
);
    import ratune_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ratune_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    ratune_datapath #(
        .P_SHIFT (P_SHIFT),
        .I_SHIFT (I_SHIFT),
        .D_SHIFT (D_SHIFT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .temp_in   (temp_sample),
        .req_in    (start_req),
        .duty_o    (duty),
        .phase_o   (phase),
        .point_o   (point_led),
        .gp_o      (gain_p),
        .gi_o      (gain_i),
        .gd_o      (gain_d),
        .gv_o      (gains_valid)
    );

endmodule

// ===== rtl/core/ratune_checker.sv =====
module ratune_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  phase,
    input logic [15:0] gain_p,
    input logic        gains_valid
);
    import ratune_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(phase))
        else $error("result changed while stalled");

    // Gains only appear with the done phase.
    a_gain_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gains_valid |-> phase == PH_DONE)
        else $error("gains outside done phase");

    a_gain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !gains_valid |-> gain_p == 16'd0)
        else $error("gain shown while not valid");

    // After an accepted request the block waits before taking another.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken too early");

endmodule

bind relay_autotune_pid_gains_top ratune_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .phase       (phase),
    .gain_p      (gain_p),
    .gains_valid (gains_valid)
);
